// ===== design/rppd_pkg.sv =====
package rppd_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int TIMER_BITS_DEF   = 16;

    localparam int STAMP_W = 16;
    localparam int CHAN_W  = 4;
    localparam int SLOT_W  = CHAN_W + 1;

    localparam logic [STAMP_W-1:0] SYNC_RESET = 16'd4000;

    // one edge request as held in the input register
    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic               rising;
    } edge_t;

    // one decoded channel pulse
    typedef struct packed {
        logic [CHAN_W-1:0]  channel;
        logic [STAMP_W-1:0] width;
        logic               frame_last;
    } result_t;

endpackage

// ===== design/rppd_in_stage.sv =====
module rppd_in_stage
    import rppd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [STAMP_W-1:0] s_tdata,
    input  logic               s_tuser,
    input  logic               take,
    output logic               item_valid,
    output edge_t              item
);

    logic  valid_reg;
    logic  valid_next;
    edge_t item_reg;
    logic  load;

    // the register frees up in the same cycle its request moves on
    assign s_tready   = !valid_reg || take;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.stamp  <= s_tdata;
            item_reg.rising <= s_tuser;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/rppd_decode.sv =====
module rppd_decode
    import rppd_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int TIMER_BITS   = TIMER_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [STAMP_W-1:0] cfg_wdata,
    input  logic               item_valid,
    input  edge_t              item,
    output logic               take,
    output logic               res_valid,
    output result_t            res,
    input  logic               res_ready
);

    localparam int CMP_BITS = (TIMER_BITS > STAMP_W) ? TIMER_BITS : STAMP_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_CHANNELS);

    logic [STAMP_W-1:0]    threshold_reg;
    logic                  expect_rising_reg;
    logic                  expect_rising_next;
    logic [TIMER_BITS-1:0] rise_stamp_reg;
    logic [TIMER_BITS-1:0] rise_stamp_next;
    logic [CHAN_W-1:0]     slot_count_reg;
    logic [CHAN_W-1:0]     slot_count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               out_reg;

    logic [TIMER_BITS-1:0] stamp;
    logic [TIMER_BITS-1:0] pulse_width;
    logic [SLOT_W-1:0]     slot;
    logic                  emit;

    assign take  = item_valid && (!out_valid_reg || res_ready);
    assign stamp = TIMER_BITS'(item.stamp);
    // modulo the timer width, so a pulse across a timer wrap still measures right
    assign pulse_width = stamp - rise_stamp_reg;
    assign slot        = SLOT_W'(slot_count_reg) + SLOT_W'(1);

    always_comb
    begin
        expect_rising_next = expect_rising_reg;
        rise_stamp_next    = rise_stamp_reg;
        slot_count_next    = slot_count_reg;
        emit               = 1'b0;
        if (take && (item.rising == expect_rising_reg))
        begin
            if (item.rising)
            begin
                rise_stamp_next    = stamp;
                expect_rising_next = 1'b0;
            end
            else
            begin
                expect_rising_next = 1'b1;
                if (CMP_BITS'(pulse_width) > CMP_BITS'(threshold_reg))
                begin
                    slot_count_next = '0;
                end
                else if (slot > LAST_SLOT)
                begin
                    // slot past the last channel is dropped
                    slot_count_next = '0;
                end
                else
                begin
                    slot_count_next = slot[CHAN_W-1:0];
                    emit            = 1'b1;
                end
            end
        end
    end

    assign out_valid_next = take ? emit : (out_valid_reg && !res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg     <= SYNC_RESET;
            expect_rising_reg <= 1'b1;
            rise_stamp_reg    <= '0;
            slot_count_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                threshold_reg <= cfg_wdata;
            end
            expect_rising_reg <= expect_rising_next;
            rise_stamp_reg    <= rise_stamp_next;
            slot_count_reg    <= slot_count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg.channel    <= slot[CHAN_W-1:0];
            out_reg.width      <= STAMP_W'(pulse_width);
            out_reg.frame_last <= (slot == LAST_SLOT);
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

// ===== design/rc_ppm_pulse_width_decoder_core.sv =====
// RC PPM decoder: each input request is one edge of the PPM pin with its 16-bit
// timer stamp (s_tuser high for rising). Edges must alternate; an edge of the
// unexpected polarity is dropped. A falling edge measures the high width modulo
// 2^TIMER_BITS; a width above the sync threshold (cfg_wdata, reset 4000 ticks)
// restarts the frame, otherwise the pulse goes out as the next channel 1 to
// NUM_CHANNELS, with m_tlast on the last one; a pulse beyond the last channel
// is dropped. One edge is taken per clock while the result is not stalled.
// An edge is held in the input register, and its result is loaded into the
// result register when the edge is taken; m_tvalid shows it from there until
// it is taken. A stalled result holds the edge behind it in the input
// register.
module rc_ppm_pulse_width_decoder_core
    import rppd_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int TIMER_BITS   = TIMER_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [STAMP_W-1:0] cfg_wdata,   // sync_threshold
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [STAMP_W-1:0] s_tdata,     // [15:0] timestamp
    input  logic               s_tuser,     // [0] rising
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [STAMP_W-1:0] m_tdata,     // [15:0] width
    output logic [CHAN_W-1:0]  m_tuser,     // [3:0] channel
    output logic               m_tlast      // frame_last
);

    logic    item_valid;
    edge_t   item;
    logic    take;
    result_t res;

    rppd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    rppd_decode #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TIMER_BITS   (TIMER_BITS)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .res_valid  (m_tvalid),
        .res        (res),
        .res_ready  (m_tready)
    );

    assign m_tdata = res.width;
    assign m_tuser = res.channel;
    assign m_tlast = res.frame_last;

endmodule

// ===== design/rppd_checker.sv =====
module rppd_checker
    import rppd_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [STAMP_W-1:0] m_tdata,
    input logic [CHAN_W-1:0]  m_tuser,
    input logic               m_tlast
);

    localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(NUM_CHANNELS);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != '0) && (m_tuser <= LAST_CHAN))
    else $error("channel out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == LAST_CHAN)))
    else $error("frame end flag does not match channel");

    // a fresh result comes from an accepted edge request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a matching edge request");

endmodule

bind rc_ppm_pulse_width_decoder_core rppd_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_rppd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/rc_ppm_pulse_width_decoder_core_tb.sv =====
`timescale 1ns / 1ps

module rc_ppm_pulse_width_decoder_core_tb;
    import rppd_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_ITEMS = 2000;
    localparam int NUM_PHASES   = 8;

    // tracks the decoder state and the channel pulses still owed by the block
    class pulse_width_scoreboard;
        logic [STAMP_W-1:0] threshold;
        logic               want_rise;
        logic [STAMP_W-1:0] rise_stamp;
        logic [CHAN_W-1:0]  slot_count;
        result_t            pending_pulses[$];
        int                 mismatches;

        function new();
            threshold   = SYNC_RESET;
            want_rise   = 1'b1;
            rise_stamp  = '0;
            slot_count  = '0;
            mismatches  = 0;
        endfunction

        function void set_threshold(logic [STAMP_W-1:0] value);
            threshold = value;
        endfunction

        function void note_failure(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $realtime, msg);
        endfunction

        // one accepted edge request
        function void decode_edge(logic [STAMP_W-1:0] stamp, logic rising);
            logic [STAMP_W-1:0] pulse;
            logic [CHAN_W:0]    next_slot;
            result_t            r;
            if (rising != want_rise)
                return;
            if (rising)
            begin
                rise_stamp = stamp;
                want_rise  = 1'b0;
                return;
            end
            want_rise = 1'b1;
            pulse = stamp - rise_stamp;
            if (pulse > threshold)
            begin
                slot_count = '0;
                return;
            end
            next_slot = {1'b0, slot_count} + 1'b1;
            if (next_slot > NUM_CHANNELS_DEF)
            begin
                // pulse beyond the last channel is dropped
                slot_count = '0;
                return;
            end
            slot_count   = next_slot[CHAN_W-1:0];
            r.channel    = next_slot[CHAN_W-1:0];
            r.width      = pulse;
            r.frame_last = (next_slot == NUM_CHANNELS_DEF);
            pending_pulses.push_back(r);
        endfunction

        function void check_pulse(logic [CHAN_W-1:0] channel, logic [STAMP_W-1:0] pulse,
                                  logic last);
            result_t exp_r;
            if (pending_pulses.size() == 0)
            begin
                note_failure($sformatf("unexpected pulse: channel %0d width %0d last %0b",
                                       channel, pulse, last));
                return;
            end
            exp_r = pending_pulses.pop_front();
            if (channel !== exp_r.channel)
                note_failure($sformatf("channel mismatch: expected %0d got %0d",
                                       exp_r.channel, channel));
            if (pulse !== exp_r.width)
                note_failure($sformatf("width mismatch on channel %0d: expected %0d got %0d",
                                       exp_r.channel, exp_r.width, pulse));
            if (last !== exp_r.frame_last)
                note_failure($sformatf("tlast mismatch on channel %0d: expected %0b got %0b",
                                       exp_r.channel, exp_r.frame_last, last));
        endfunction

        function void check_leftover();
            if (pending_pulses.size() != 0)
                note_failure($sformatf("%0d pulses never came out", pending_pulses.size()));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [STAMP_W-1:0] cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [STAMP_W-1:0] s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [STAMP_W-1:0] m_tdata;
    logic [CHAN_W-1:0]  m_tuser;
    logic               m_tlast;

    pulse_width_scoreboard book;
    int                    cycles;
    int                    items_sent;
    int                    stall_left;
    logic                  calm;

    rc_ppm_pulse_width_decoder_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                book.check_pulse(m_tuser, m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                book.decode_edge(s_tdata, s_tuser);
        end
    end

    // mostly short gaps, now and then a long one, none while calm
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic send_edge(input logic [STAMP_W-1:0] stamp, input logic rising);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = stamp;
        s_tuser  = rising;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_pulse(input logic [STAMP_W-1:0] pulse);
        logic [STAMP_W-1:0] rise_at;
        rise_at = STAMP_W'($urandom_range(0, 65535));
        send_edge(rise_at, 1'b1);
        send_edge(rise_at + pulse, 1'b0);
    endtask

    // wait for the block to go quiet before touching the threshold
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (book.pending_pulses.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [STAMP_W-1:0] value);
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        book.set_threshold(value);
    endtask

    function automatic logic [STAMP_W-1:0] channel_width();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return book.threshold;
        if (r == 1)
            return '0;
        return STAMP_W'($urandom_range(0, book.threshold));
    endfunction

    function automatic logic [STAMP_W-1:0] sync_width();
        int r;
        // no pulse can exceed the widest threshold
        if (book.threshold == 16'hFFFF)
            return STAMP_W'($urandom_range(0, 65535));
        r = $urandom_range(0, 9);
        if (r == 0)
            return book.threshold + 1'b1;
        if (r == 1)
            return 16'hFFFF;
        return STAMP_W'($urandom_range(book.threshold + 1, 65535));
    endfunction

    task automatic send_frame();
        int slots;
        int r;
        calm = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 4))
                send_edge(STAMP_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        end
        send_pulse(sync_width());
        r = $urandom_range(0, 9);
        if (r < 6)
            slots = NUM_CHANNELS_DEF;
        else if (r < 8)
            slots = $urandom_range(NUM_CHANNELS_DEF + 1, NUM_CHANNELS_DEF + 3);
        else
            slots = $urandom_range(0, NUM_CHANNELS_DEF - 1);
        for (int k = 0; k < slots; k++)
            send_pulse(channel_width());
    endtask

    initial
    begin
        logic [STAMP_W-1:0] phase_thr;
        book       = new();
        cycles     = 0;
        items_sent = 0;
        stall_left = 0;
        calm       = 1'b0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed edges against the reset threshold
        send_edge(16'd100, 1'b0);       // falling while a rising edge is due
        send_edge(16'd0, 1'b1);
        send_edge(16'd5, 1'b1);         // second rising edge is dropped
        send_edge(16'd4000, 1'b0);      // width equal to threshold is a channel
        send_edge(16'd100, 1'b1);
        send_edge(16'd4101, 1'b0);      // one tick over threshold: sync
        send_edge(16'hFFFF, 1'b1);
        send_edge(16'd999, 1'b0);       // pulse across the timer wrap
        send_edge(16'd7, 1'b1);
        send_edge(16'd7, 1'b0);         // zero width
        send_edge(16'd7, 1'b0);         // repeated falling edge is dropped
        send_edge(16'd0, 1'b1);
        send_edge(16'hFFFF, 1'b0);      // widest pulse: sync

        // widest threshold, then narrowest
        wait_idle();
        write_threshold(16'hFFFF);
        send_pulse(16'hFFFF);
        wait_idle();
        write_threshold(16'h0000);
        send_pulse(16'h0000);
        send_pulse(16'h0001);
        send_pulse(16'h0000);

        items_sent = 0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: phase_thr = 16'hFFFF;
                1: phase_thr = 16'h0000;
                2: phase_thr = 16'h0001;
                3: phase_thr = SYNC_RESET;
                4: phase_thr = 16'hFFFE;
                default: phase_thr = STAMP_W'($urandom_range(0, 65535));
            endcase
            wait_idle();
            write_threshold(phase_thr);
            while (items_sent < (p + 1) * RANDOM_ITEMS / NUM_PHASES)
                send_frame();
        end

        wait_idle();
        book.check_leftover();
        if (book.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/rppd_pkg.sv
design/rppd_in_stage.sv
design/rppd_decode.sv
design/rc_ppm_pulse_width_decoder_core.sv
design/rppd_checker.sv
tb/rc_ppm_pulse_width_decoder_core_tb.sv
